@@ hdl/double_ended_stack_allocator_core_macros.svh @@
// Assertion helpers shared by the allocator RTL.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_CORE_MACROS_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define DESA_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define DESA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DESA_ASSERT(name, clk, rst, expr)
`define DESA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ hdl/desa_pkg.sv @@
package desa_pkg;

   localparam int ADDR_W = 17;
   localparam logic [ADDR_W-1:0] REGION_RESET = 17'd4096;

   typedef enum logic [2:0] {
      ACT_ALLOC_FRONT = 3'd0,
      ACT_ALLOC_BACK  = 3'd1,
      ACT_FREE_FRONT  = 3'd2,
      ACT_FREE_BACK   = 3'd3,
      ACT_RESET       = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_ALIGN  = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_SIDE_EMPTY = 3'd3,
      ST_NOT_LIFO   = 3'd4,
      ST_STACK_FULL = 3'd5
   } status_type;

   // One stack record: block start and the side's free pointer before the push.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] prev;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clr;
   } stack_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

@@ hdl/double_ended_stack_allocator_core.sv @@
// A request is registered in the input stage and resolved into the output stage.
// Throughput: one request per cycle unless a held response stalls; free pointers
// and both stack tops update in the same cycle that a request is resolved.
// Reset (synchronous): region 4096 bytes, both sides empty, front free 0,
// back free at the region end, no request or response held.
`include "double_ended_stack_allocator_core_macros.svh"

module double_ended_stack_allocator_core #(
   parameter int REGION_MAX   = 65536,
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int GUARD_BYTES  = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = action[2:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,
   // tdata: size[16:0], alignment[33:17], block_address[50:34], zero pad
   input  logic [55:0] req_tdata,
   // response: tuser = status[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,
   // tdata: result_address[16:0], front_free_now[33:17], back_free_now[50:34]
   output logic [55:0] rsp_tdata,
   // region_size write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_wdata
);

   localparam int AW = desa_pkg::ADDR_W;
   localparam int WW = AW + 3;
   localparam logic [WW-1:0] GB  = WW'(GUARD_BYTES);
   localparam logic [WW-1:0] HG  = WW'(HEADER_BYTES + GUARD_BYTES);
   localparam logic [24:0]   RMAX = 25'(REGION_MAX);

   // input stage
   logic          in_vld_ff, in_vld_in;
   logic [2:0]    act_ff;
   logic [AW-1:0] size_ff, align_ff, blk_ff;

   // state
   logic [AW-1:0] region_ff, region_in;
   logic [AW-1:0] front_free_ff, front_free_in;
   logic [AW-1:0] back_free_ff, back_free_in;

   // output stage
   logic                 out_vld_ff, out_vld_in;
   desa_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        ffree_ff, bfree_ff;

   logic adv, go, csr_fire, req_fire;

   desa_pkg::stack_cmd_type  f_cmd, b_cmd;
   desa_pkg::stack_stat_type f_stat, b_stat;
   desa_pkg::entry_type      f_push, b_push, f_top, b_top;

   logic          align_ok;
   logic [WW-1:0] amask, ff_x, bf_x, size_x;
   logic [WW-1:0] f_base, f_pos, f_end, b_need, b_pos, b_lim;

   assign adv        = !out_vld_ff || rsp_tready;
   assign go         = in_vld_ff && adv;
   assign req_tready = !in_vld_ff || adv;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !in_vld_ff;
   assign csr_fire   = csr_valid && csr_ready;
   assign in_vld_in  = req_fire ? 1'b1 : (go ? 1'b0 : in_vld_ff);
   assign out_vld_in = go ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff   <= req_tuser;
         size_ff  <= req_tdata[16:0];
         align_ff <= req_tdata[33:17];
         blk_ff   <= req_tdata[50:34];
      end
   end

   // allocation arithmetic, wide enough that the sums do not overflow
   assign align_ok = (align_ff != '0) && ((align_ff & (align_ff - AW'(1))) == '0);
   assign amask    = {3'b000, align_ff - AW'(1)};
   assign ff_x     = {3'b000, front_free_ff};
   assign bf_x     = {3'b000, back_free_ff};
   assign size_x   = {3'b000, size_ff};
   assign f_base   = ff_x + HG;
   assign f_pos    = (f_base + amask) & ~amask;
   assign f_end    = f_pos + size_x + GB;
   assign b_need   = size_x + GB;
   assign b_pos    = (bf_x - b_need) & ~amask;
   assign b_lim    = ff_x + HG;

   assign f_push = '{start: f_pos[AW-1:0], prev: front_free_ff};
   assign b_push = '{start: b_pos[AW-1:0], prev: back_free_ff};

   always_comb begin
      region_in     = region_ff;
      front_free_in = front_free_ff;
      back_free_in  = back_free_ff;
      status_in     = desa_pkg::ST_OK;
      addr_in       = '0;
      f_cmd         = '0;
      b_cmd         = '0;
      if (csr_fire) begin
         region_in     = ({8'b0, csr_wdata} > RMAX) ? RMAX[AW-1:0] : csr_wdata;
         front_free_in = '0;
         back_free_in  = region_in;
         f_cmd.clr     = 1'b1;
         b_cmd.clr     = 1'b1;
      end else if (go) begin
         case (act_ff)
            desa_pkg::ACT_ALLOC_FRONT: begin
               if (!align_ok) begin
                  status_in = desa_pkg::ST_BAD_ALIGN;
               end else if (f_end > bf_x) begin
                  status_in = desa_pkg::ST_NO_SPACE;
               end else if (f_stat.full) begin
                  status_in = desa_pkg::ST_STACK_FULL;
               end else begin
                  f_cmd.push    = 1'b1;
                  front_free_in = f_end[AW-1:0];
                  addr_in       = f_pos[AW-1:0];
               end
            end
            desa_pkg::ACT_ALLOC_BACK: begin
               if (!align_ok) begin
                  status_in = desa_pkg::ST_BAD_ALIGN;
               end else if ((bf_x < b_need) || (b_pos < b_lim)) begin
                  status_in = desa_pkg::ST_NO_SPACE;
               end else if (b_stat.full) begin
                  status_in = desa_pkg::ST_STACK_FULL;
               end else begin
                  b_cmd.push   = 1'b1;
                  back_free_in = AW'(b_pos - HG);
                  addr_in      = b_pos[AW-1:0];
               end
            end
            desa_pkg::ACT_FREE_FRONT: begin
               if (f_stat.empty) begin
                  status_in = desa_pkg::ST_SIDE_EMPTY;
               end else if (f_top.start != blk_ff) begin
                  status_in = desa_pkg::ST_NOT_LIFO;
               end else begin
                  f_cmd.pop     = 1'b1;
                  front_free_in = f_top.prev;
               end
            end
            desa_pkg::ACT_FREE_BACK: begin
               if (b_stat.empty) begin
                  status_in = desa_pkg::ST_SIDE_EMPTY;
               end else if (b_top.start != blk_ff) begin
                  status_in = desa_pkg::ST_NOT_LIFO;
               end else begin
                  b_cmd.pop    = 1'b1;
                  back_free_in = b_top.prev;
               end
            end
            desa_pkg::ACT_RESET: begin
               f_cmd.clr     = 1'b1;
               b_cmd.clr     = 1'b1;
               front_free_in = '0;
               back_free_in  = region_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff     <= desa_pkg::REGION_RESET;
         front_free_ff <= '0;
         back_free_ff  <= desa_pkg::REGION_RESET;
      end else begin
         region_ff     <= region_in;
         front_free_ff <= front_free_in;
         back_free_ff  <= back_free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         status_ff <= status_in;
         addr_ff   <= addr_in;
         ffree_ff  <= front_free_in;
         bfree_ff  <= back_free_in;
      end
   end

   desa_stack #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cmd        (f_cmd),
      .push_entry (f_push),
      .top_entry  (f_top),
      .stat       (f_stat)
   );

   desa_stack #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (b_cmd),
      .push_entry (b_push),
      .top_entry  (b_top),
      .stat       (b_stat)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'b00000, bfree_ff, ffree_ff, addr_ff};

   `DESA_ASSERT(a_sides_ordered, clock, reset, front_free_ff <= back_free_ff)
   `DESA_ASSERT(a_refused_zero, clock, reset,
                !out_vld_ff || (status_ff == desa_pkg::ST_OK) || (addr_ff == '0))
   `DESA_ASSERT_NEXT(a_csr_clears, clock, reset, csr_fire,
                     (front_free_ff == '0) && (back_free_ff == region_ff))

endmodule

@@ hdl/desa_stack.sv @@
`include "double_ended_stack_allocator_core_macros.svh"

module desa_stack #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  desa_pkg::stack_cmd_type    cmd,
   input  desa_pkg::entry_type        push_entry,
   output desa_pkg::entry_type        top_entry,
   output desa_pkg::stack_stat_type   stat
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   // Top entry lives in flops; entries below it live in the memory.
   desa_pkg::entry_type mem [MAX_BLOCKS];

   logic [CNT_W-1:0]    count_ff, count_in;
   desa_pkg::entry_type top_ff, top_in;
   desa_pkg::entry_type below_ff;
   logic [CNT_W-1:0]    wr_full, rd_full;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic                empty, full, wr_en;

   assign empty = (count_ff == '0);
   assign full  = (count_ff >= CNT_W'(MAX_BLOCKS));
   assign stat  = '{empty: empty, full: full};
   assign top_entry = top_ff;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = push_entry;
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = below_ff;
      end
   end

   assign wr_en   = cmd.push && !cmd.clr && !empty;
   assign wr_full = count_ff - CNT_W'(1);
   assign wr_addr = wr_full[IDX_W-1:0];
   // below_ff tracks the entry under the next top
   assign rd_full = count_in - CNT_W'(2);
   assign rd_addr = rd_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
   end

   `DESA_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(MAX_BLOCKS))
   `DESA_ASSERT(a_push_pop_excl, clock, reset, !(cmd.push && cmd.pop))
   `DESA_ASSERT(a_pop_nonempty, clock, reset, !cmd.pop || !empty)
   `DESA_ASSERT_NEXT(a_clr_empties, clock, reset, cmd.clr, count_ff == '0)

endmodule
